@@ rtl/uelt_pkg.sv @@
// Shared types and constants for the upper envelope line table.
// Holds table sizing, transaction payload structs and status codes.
// Depends on nothing; every other file imports it.
`default_nettype none

package uelt_pkg;

  // Table capacity and derived widths
  localparam int MAX_LINES = 64;
  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int LCNT_W    = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REDUNDANT = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] query_x;
  } req_t;

  typedef struct packed {
    logic signed [63:0] envelope_value;
    status_t            status;
    logic [LCNT_W-1:0]  line_count_out;
  } rsp_t;

  // One table entry
  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
  } line_t;

  // Sign extend a 32-bit value by one bit
  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

endpackage

`default_nettype wire

@@ rtl/uelt_ram.sv @@
// Line table storage: one write port, one read port, registered read data.
// Depends on uelt_pkg for the entry type and address width.
`default_nettype none

module uelt_ram
  import uelt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output line_t                 rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire line_t            wr_data
);

  line_t mem [MAX_LINES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/upper_envelope_line_table.sv @@
// Upper envelope line table: sequencer around the line memory.
// Depends on uelt_pkg and uelt_ram.
//
// Keeps lines sorted by slope in one memory and serves one transaction at a
// time; req_stall is high while a transaction is worked on, and a finished
// response waits in the output register while the next request is taken.
// An insert scans for its place and runs the first redundancy test; a taken
// line then has neighbors tested and pruned on each side, and lines are
// moved when the table is compacted. A query walks the lines and evaluates
// the chosen line; a query on an empty table does neither. Any time the
// output register stays full under rsp_stall comes on top. The run time is
// set by the single memory read port and the one shared 33x33 multiplier.
// The memory needs no clearing after reset: only entries below the line
// count are ever read.
`default_nettype none

module upper_envelope_line_table
  import uelt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_SC_RD, S_SC_WT,
    S_T_OP1, S_T_M1, S_T_M2, S_T_CMP,
    S_R_CHK, S_R_RD, S_R_WT, S_R_WT2,
    S_L_CHK, S_L_RD, S_L_WT, S_L_WT2,
    S_CP_START, S_CP_RD, S_CP_WR, S_WR_NEW,
    S_Q_RD0, S_Q_WT0, S_Q_CHK, S_Q_WT, S_Q_OP, S_Q_M, S_Q_CMP,
    S_V_OP, S_V_M, S_V_ADD, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CTX_NEW, CTX_RIGHT, CTX_LEFT
  } ctx_t;

  state_t state;
  ctx_t   ctx;

  logic [CNT_W-1:0] cnt, idx, p, a, bi, src, dst;
  logic             dir_up;
  logic signed [31:0] m, b, qx;
  logic               hx, hz;
  logic signed [31:0] xm, xb, ym, yb, zm, zb;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p1, p2;
  logic signed [65:0] prod;
  logic signed [63:0] res_val;
  status_t            res_st;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  line_t              rd_data, wr_data;

  logic [CNT_W-1:0]   idx_inc, bi_inc, a_dec, a_dec2;
  logic               red;
  logic signed [32:0] qdiff;
  logic signed [65:0] qdiff_w;
  logic               rsp_load;

  uelt_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign req_stall = (state != S_IDLE);

  // Output register takes a finished transaction once it is free
  assign rsp_load = (state == S_FIN) && (!rsp_valid || !rsp_stall);

  assign idx_inc = idx + 1'b1;
  assign bi_inc  = bi + 1'b1;
  assign a_dec   = a - 1'b1;
  assign a_dec2  = a - 2'd2;

  // Shared multiplier, operands registered
  assign prod = mul_a * mul_b;

  // Redundancy of the middle line y between x and z
  always_comb begin
    if (!hx) begin
      red = hz && (ym == zm) && (yb <= zb);
    end else if (!hz) begin
      red = (ym == xm) && (yb <= xb);
    end else begin
      red = (p1 >= p2);
    end
  end

  assign qdiff   = sx33(yb) - sx33(zb);
  assign qdiff_w = {{33{qdiff[32]}}, qdiff};

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = a[IDX_W-1:0];
    wr_data = '{slope: m, intercept: b};
    unique case (state)
      S_SC_RD: begin
        rd_en = 1'b1;
      end
      S_R_RD: begin
        rd_en   = 1'b1;
        rd_addr = bi[IDX_W-1:0];
      end
      S_R_WT: begin
        rd_en   = (bi_inc < cnt);
        rd_addr = bi_inc[IDX_W-1:0];
      end
      S_L_RD: begin
        rd_en   = 1'b1;
        rd_addr = a_dec[IDX_W-1:0];
      end
      S_L_WT: begin
        rd_en   = (a > 1);
        rd_addr = a_dec2[IDX_W-1:0];
      end
      S_CP_RD: begin
        rd_en   = 1'b1;
        rd_addr = src[IDX_W-1:0];
      end
      S_CP_WR: begin
        wr_en   = 1'b1;
        wr_addr = dst[IDX_W-1:0];
        wr_data = rd_data;
      end
      S_WR_NEW: begin
        wr_en = 1'b1;
      end
      S_Q_RD0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_Q_CHK: begin
        rd_en   = (idx_inc != cnt);
        rd_addr = idx_inc[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Load a finished transaction, or drop the one just taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            m       <= req.slope;
            b       <= req.intercept;
            qx      <= req.query_x;
            ym      <= req.slope;
            yb      <= req.intercept;
            hx      <= 1'b0;
            hz      <= 1'b0;
            idx     <= '0;
            p       <= '0;
            res_val <= '0;
            res_st  <= ST_OK;
            ctx     <= CTX_NEW;
            if (req.opcode == OP_INSERT) begin
              state <= (cnt == 0) ? S_T_OP1 : S_SC_RD;
            end else if (cnt == 0) begin
              res_st <= ST_EMPTY;
              state  <= S_FIN;
            end else begin
              state <= S_Q_RD0;
            end
          end
        end

        // Find the place after all slopes not above the new one
        S_SC_RD: state <= S_SC_WT;
        S_SC_WT: begin
          if (rd_data.slope <= m) begin
            xm <= rd_data.slope;
            xb <= rd_data.intercept;
            hx <= 1'b1;
            if (idx_inc == cnt) begin
              p     <= cnt;
              state <= S_T_OP1;
            end else begin
              idx   <= idx_inc;
              state <= S_SC_RD;
            end
          end else begin
            zm    <= rd_data.slope;
            zb    <= rd_data.intercept;
            hz    <= 1'b1;
            p     <= idx;
            state <= S_T_OP1;
          end
        end

        // Cross-multiplied intersection test
        S_T_OP1: begin
          mul_a <= sx33(xb) - sx33(yb);
          mul_b <= sx33(zm) - sx33(ym);
          state <= S_T_M1;
        end
        S_T_M1: begin
          p1    <= prod;
          mul_a <= sx33(yb) - sx33(zb);
          mul_b <= sx33(ym) - sx33(xm);
          state <= S_T_M2;
        end
        S_T_M2: begin
          p2    <= prod;
          state <= S_T_CMP;
        end
        S_T_CMP: begin
          unique case (ctx)
            CTX_NEW: begin
              if (red) begin
                res_st <= ST_REDUNDANT;
                state  <= S_FIN;
              end else if (cnt >= CNT_W'(MAX_LINES)) begin
                res_st <= ST_FULL;
                state  <= S_FIN;
              end else begin
                bi    <= p;
                state <= S_R_CHK;
              end
            end
            CTX_RIGHT: begin
              if (red) begin
                bi    <= bi_inc;
                state <= S_R_CHK;
              end else begin
                a     <= p;
                state <= S_L_CHK;
              end
            end
            CTX_LEFT: begin
              if (red) begin
                a     <= a_dec;
                state <= S_L_CHK;
              end else begin
                state <= S_CP_START;
              end
            end
            default: state <= S_CP_START;
          endcase
        end

        // Prune neighbors on the higher slope side
        S_R_CHK: begin
          if (bi == cnt) begin
            a     <= p;
            state <= S_L_CHK;
          end else begin
            xm    <= m;
            xb    <= b;
            hx    <= 1'b1;
            ctx   <= CTX_RIGHT;
            state <= S_R_RD;
          end
        end
        S_R_RD: state <= S_R_WT;
        S_R_WT: begin
          ym    <= rd_data.slope;
          yb    <= rd_data.intercept;
          hz    <= (bi_inc < cnt);
          state <= (bi_inc < cnt) ? S_R_WT2 : S_T_OP1;
        end
        S_R_WT2: begin
          zm    <= rd_data.slope;
          zb    <= rd_data.intercept;
          state <= S_T_OP1;
        end

        // Prune neighbors on the lower slope side
        S_L_CHK: begin
          if (a == 0) begin
            state <= S_CP_START;
          end else begin
            zm    <= m;
            zb    <= b;
            hz    <= 1'b1;
            hx    <= (a > 1);
            ctx   <= CTX_LEFT;
            state <= S_L_RD;
          end
        end
        S_L_RD: state <= S_L_WT;
        S_L_WT: begin
          ym    <= rd_data.slope;
          yb    <= rd_data.intercept;
          state <= (a > 1) ? S_L_WT2 : S_T_OP1;
        end
        S_L_WT2: begin
          xm    <= rd_data.slope;
          xb    <= rd_data.intercept;
          state <= S_T_OP1;
        end

        // Move the kept upper part next to the new line
        S_CP_START: begin
          if (bi == cnt) begin
            state <= S_WR_NEW;
          end else if (bi > a + 1'b1) begin
            src    <= bi;
            dst    <= a + 1'b1;
            dir_up <= 1'b1;
            state  <= S_CP_RD;
          end else if (bi == a) begin
            src    <= cnt - 1'b1;
            dst    <= cnt;
            dir_up <= 1'b0;
            state  <= S_CP_RD;
          end else begin
            state <= S_WR_NEW;
          end
        end
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          if (dir_up) begin
            if (src + 1'b1 == cnt) begin
              state <= S_WR_NEW;
            end else begin
              src   <= src + 1'b1;
              dst   <= dst + 1'b1;
              state <= S_CP_RD;
            end
          end else begin
            if (src == bi) begin
              state <= S_WR_NEW;
            end else begin
              src   <= src - 1'b1;
              dst   <= dst - 1'b1;
              state <= S_CP_RD;
            end
          end
        end
        S_WR_NEW: begin
          cnt   <= CNT_W'(a + 1'b1 + (cnt - bi));
          state <= S_FIN;
        end

        // Walk the envelope until a line is not below its successor
        S_Q_RD0: state <= S_Q_WT0;
        S_Q_WT0: begin
          ym    <= rd_data.slope;
          yb    <= rd_data.intercept;
          state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          state <= (idx_inc == cnt) ? S_V_OP : S_Q_WT;
        end
        S_Q_WT: begin
          zm    <= rd_data.slope;
          zb    <= rd_data.intercept;
          state <= S_Q_OP;
        end
        S_Q_OP: begin
          mul_a <= sx33(zm) - sx33(ym);
          mul_b <= sx33(qx);
          state <= S_Q_M;
        end
        S_Q_M: begin
          p1    <= prod;
          state <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if (qdiff_w >= p1) begin
            state <= S_V_OP;
          end else begin
            ym    <= zm;
            yb    <= zb;
            idx   <= idx_inc;
            state <= S_Q_CHK;
          end
        end

        // Evaluate the chosen line
        S_V_OP: begin
          mul_a <= sx33(ym);
          mul_b <= sx33(qx);
          state <= S_V_M;
        end
        S_V_M: begin
          p1    <= prod;
          state <= S_V_ADD;
        end
        S_V_ADD: begin
          res_val <= p1[63:0] + {{32{yb[31]}}, yb};
          state   <= S_FIN;
        end

        // Hold until the output register is free
        S_FIN: begin
          if (rsp_load) begin
            rsp.envelope_value <= res_val;
            rsp.status         <= res_st;
            rsp.line_count_out <= LCNT_W'(cnt);
            state              <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/uelt_checker.sv @@
// Port-level checks for the upper envelope line table, bound to the top.
// Depends on uelt_pkg and upper_envelope_line_table.
`default_nettype none

module uelt_checker
  import uelt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // Hold a stalled response transaction
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Clear the response after reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Empty table reports no lines and a zero value
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |->
      rsp.envelope_value == 0 && rsp.line_count_out == 0)
    else $error("empty query with lines or value");

  // Full table reports the capacity and a zero value
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |->
      rsp.envelope_value == 0 && rsp.line_count_out == LCNT_W'(MAX_LINES))
    else $error("full flag without full table");

endmodule

bind upper_envelope_line_table uelt_checker u_chk (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the upper envelope line table: directed table plus random traffic.
// Depends on uelt_pkg and the upper_envelope_line_table RTL; self-checking, no files.
`timescale 1ns / 1ps

module tb;
  import uelt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  upper_envelope_line_table i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Envelope state mirrored in the testbench
  logic signed [63:0] env_m [0:MAX_LINES];
  logic signed [63:0] env_b [0:MAX_LINES];
  int                 env_count;
  rsp_t               pending_rsp [$];
  int                 mismatches = 0;
  bit                 hold_off = 1'b0;

  // a*b >= c*d exactly; operands fit in 33 bits, products in 66
  function automatic bit prod_ge(input logic signed [63:0] a, input logic signed [63:0] b,
                                 input logic signed [63:0] c, input logic signed [63:0] d);
    logic signed [127:0] p1, p2;
    p1 = 128'(a) * 128'(b);
    p2 = 128'(c) * 128'(d);
    return p1 >= p2;
  endfunction

  function automatic bit line_useless(input bit hx, input logic signed [63:0] xm,
                                      input logic signed [63:0] xb,
                                      input logic signed [63:0] ym,
                                      input logic signed [63:0] yb, input bit hz,
                                      input logic signed [63:0] zm,
                                      input logic signed [63:0] zb);
    if (!hx) return hz && ym == zm && yb <= zb;
    if (!hz) return ym == xm && yb <= xb;
    return prod_ge(xb - yb, zm - ym, yb - zb, ym - xm);
  endfunction

  function automatic bit useless_at(input int i);
    int xi, zi;
    xi = (i > 0) ? i - 1 : i;
    zi = (i + 1 < env_count) ? i + 1 : i;
    return line_useless(i > 0, env_m[xi], env_b[xi], env_m[i], env_b[i],
                        i + 1 < env_count, env_m[zi], env_b[zi]);
  endfunction

  function automatic void drop_line(input int i);
    for (int k = i; k + 1 < env_count; k++) begin
      env_m[k] = env_m[k + 1];
      env_b[k] = env_b[k + 1];
    end
    env_count--;
  endfunction

  // Compute the response for one transaction and advance the mirror
  function automatic rsp_t envelope_step(input req_t r);
    rsp_t o;
    logic signed [63:0] m, b, x;
    int p, i;
    o = '0;
    o.status = ST_OK;
    if (r.opcode == OP_INSERT) begin
      m = r.slope;
      b = r.intercept;
      p = 0;
      while (p < env_count && env_m[p] <= m) p++;
      if (line_useless(p > 0, env_m[(p > 0) ? p - 1 : 0], env_b[(p > 0) ? p - 1 : 0], m, b,
                       p < env_count, env_m[p], env_b[p]))
        o.status = ST_REDUNDANT;
      else if (env_count >= MAX_LINES)
        o.status = ST_FULL;
      if (o.status == ST_OK) begin
        for (int k = env_count; k > p; k--) begin
          env_m[k] = env_m[k - 1];
          env_b[k] = env_b[k - 1];
        end
        env_m[p] = m;
        env_b[p] = b;
        env_count++;
        while (p + 1 < env_count && useless_at(p + 1)) drop_line(p + 1);
        while (p > 0 && useless_at(p - 1)) begin
          drop_line(p - 1);
          p--;
        end
      end
    end else if (env_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      x = r.query_x;
      i = 0;
      while (i + 1 < env_count &&
             !prod_ge(env_b[i] - env_b[i + 1], 1, env_m[i + 1] - env_m[i], x))
        i++;
      o.envelope_value = env_m[i] * x + env_b[i];
    end
    o.line_count_out = env_count[LCNT_W-1:0];
    return o;
  endfunction

  // Directed rows: request, typed-in response, and whether to use it
  typedef struct {
    req_t r;
    rsp_t e;
    bit   typed;
  } row_t;
  row_t dir_rows [$];

  function automatic req_t mk(input opcode_t op, input logic [31:0] m, input logic [31:0] b,
                              input logic [31:0] x);
    req_t r;
    r.opcode = op;
    r.slope = m;
    r.intercept = b;
    r.query_x = x;
    return r;
  endfunction

  function automatic rsp_t mr(input logic [63:0] v, input status_t s, input int n);
    rsp_t o;
    o.envelope_value = v;
    o.status = s;
    o.line_count_out = n[LCNT_W-1:0];
    return o;
  endfunction

  task automatic add_row(input req_t r, input bit typed, input rsp_t e);
    row_t w;
    w.r = r;
    w.e = e;
    w.typed = typed;
    dir_rows = {dir_rows, w};
  endtask

  function automatic req_t rand_req(input int mode);
    req_t r;
    r.opcode = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY;
    r.query_x = $urandom;
    r.slope = $urandom;
    r.intercept = $urandom;
    // Mostly small values so envelopes stay long and pruning happens often
    if (mode < 6) begin
      r.slope = $signed($urandom_range(0, 200)) - 100;
      r.intercept = $signed($urandom_range(0, 20000)) - 10000;
      if ($urandom_range(0, 3) != 0) r.query_x = $signed($urandom_range(0, 400)) - 200;
    end else if (mode == 6) begin
      // Lines at or just below tangents to a parabola, so that envelopes grow long
      r.slope = $signed($urandom_range(0, 4000)) - 2000;
      r.intercept = -((r.slope * r.slope) >>> 2) - $urandom_range(0, 1);
    end
    return r;
  endfunction

  // Check each response against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response value=%0d status=%0d count=%0d",
                   rsp.envelope_value, rsp.status, rsp.line_count_out);
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value=%0d status=%0d count=%0d got value=%0d status=%0d count=%0d",
                     e.envelope_value, e.status, e.line_count_out,
                     rsp.envelope_value, rsp.status, rsp.line_count_out);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      phase++;
      if ((phase / 200) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 40);
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_req(input req_t r, input rsp_t exp_rsp);
    req <= r;
    req_valid <= 1'b1;
    pending_rsp = {pending_rsp, exp_rsp};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  int burst;

  task automatic pace();
    if (burst > 0) begin
      burst--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst = $urandom_range(0, 30);
    end
  endtask

  initial begin
    req_t r;
    rsp_t e;
    int mode;
    env_count = 0;
    burst = 0;
    // Empty, extremes, equal slopes, full-width products
    add_row(mk(OP_QUERY, 0, 0, 32'h8000_0000), 1, mr(0, ST_EMPTY, 0));
    add_row(mk(OP_INSERT, 32'h8000_0000, 32'h8000_0000, 0), 1, mr(0, ST_OK, 1));
    add_row(mk(OP_QUERY, 0, 0, 32'h8000_0000), 0, '0);
    add_row(mk(OP_QUERY, 0, 0, 32'h7fff_ffff), 0, '0);
    add_row(mk(OP_INSERT, 32'h8000_0000, 32'h8000_0000, 0), 1, mr(0, ST_REDUNDANT, 1));
    add_row(mk(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 5), 1, mr(0, ST_OK, 2));
    add_row(mk(OP_INSERT, 0, 32'h8000_0000, 0), 1, mr(0, ST_REDUNDANT, 2));
    add_row(mk(OP_INSERT, 0, 32'h7fff_ffff, 0), 0, '0);
    add_row(mk(OP_INSERT, 0, 32'h7fff_fff0, 0), 0, '0);
    add_row(mk(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 0), 0, '0);
    add_row(mk(OP_QUERY, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff), 0, '0);
    add_row(mk(OP_QUERY, 0, 0, 0), 0, '0);
    add_row(mk(OP_QUERY, 0, 0, 32'hffff_ffff), 0, '0);
    add_row(mk(OP_QUERY, 0, 0, 32'h8000_0000), 0, '0);
    add_row(mk(OP_INSERT, 1, 32'hffff_ffff, 32'hffff_ffff), 0, '0);
    add_row(mk(OP_INSERT, 32'hffff_ffff, 32'h7fff_ffff, 0), 0, '0);
    add_row(mk(OP_QUERY, 0, 0, 1), 0, '0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      e = envelope_step(dir_rows[i].r);
      if (dir_rows[i].typed && e !== dir_rows[i].e) begin
        mismatches++;
        $display("directed row %0d: typed response disagrees with predictor", i);
      end
      send_req(dir_rows[i].r, dir_rows[i].typed ? dir_rows[i].e : e);
    end
    // Random part; fill the table to capacity midway and force a long hold-off
    for (int n = 0; n < 800; n++) begin
      mode = (n >= 300 && n < 420) ? 6 : $urandom_range(0, 7);
      r = rand_req(mode);
      if (mode == 6) r.opcode = (n % 5 == 4) ? OP_QUERY : OP_INSERT;
      if (n == 380) hold_off = 1'b1;
      send_req(r, envelope_step(r));
      pace();
    end
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("upper_envelope_line_table test passed");
    else
      $display("upper_envelope_line_table test failed");
    $finish;
  end

  // Stop a hung run
  initial begin
    #40ms;
    $display("upper_envelope_line_table test failed");
    $finish;
  end

endmodule
